// File: src/brle_pkg.sv
// shared types and constants for the bmp rle8 stream decoder
// no dependencies

package brle_pkg;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic [7:0] run_length;
      logic       end_of_bitmap;
   } brle_run_type;

endpackage

// File: src/brle_front.sv
// front parser: accepts encoded bytes and classifies them into run descriptors
// depends on brle_pkg

module brle_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_enc_byte,
   input  logic                  req_frame_start,
   input  logic                  q_full,
   output logic                  q_push,
   output brle_pkg::brle_run_type q_data
);

   localparam logic [2:0] PH_COUNT   = 3'd0;
   localparam logic [2:0] PH_VALUE   = 3'd1;
   localparam logic [2:0] PH_ESCAPE  = 3'd2;
   localparam logic [2:0] PH_LITERAL = 3'd3;
   localparam logic [2:0] PH_PAD     = 3'd4;
   localparam logic [2:0] PH_SKIP    = 3'd5;
   localparam logic [2:0] PH_STOPPED = 3'd6;

   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] lit_ff, lit_in;
   logic       pad_ff, pad_in;
   logic [1:0] skip_ff, skip_in;

   logic [2:0] phase_cur;
   logic [7:0] held_cur;
   logic [7:0] lit_cur;
   logic [7:0] lit_dec;
   logic       pad_cur;
   logic [1:0] skip_cur;
   logic [1:0] skip_dec;
   logic       emit;
   logic       accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && emit;

   always_comb begin
      phase_cur = req_frame_start ? PH_COUNT : phase_ff;
      held_cur  = req_frame_start ? 8'd0 : held_ff;
      lit_cur   = req_frame_start ? 8'd0 : lit_ff;
      pad_cur   = req_frame_start ? 1'b0 : pad_ff;
      skip_cur  = req_frame_start ? 2'd0 : skip_ff;
      lit_dec   = lit_cur - 8'd1;
      skip_dec  = skip_cur - 2'd1;

      phase_in = phase_cur;
      held_in  = held_cur;
      lit_in   = lit_cur;
      pad_in   = pad_cur;
      skip_in  = skip_cur;
      emit     = 1'b0;
      q_data   = '{pixel_value: 8'd0, run_length: 8'd0, end_of_bitmap: 1'b0};

      case (phase_cur)
         PH_VALUE: begin
            emit     = 1'b1;
            q_data   = '{pixel_value: req_enc_byte, run_length: held_cur,
                         end_of_bitmap: 1'b0};
            held_in  = 8'd0;
            phase_in = PH_COUNT;
         end
         PH_ESCAPE: begin
            if (req_enc_byte == ESC_EOL) begin
               phase_in = PH_COUNT;
            end else if (req_enc_byte == ESC_EOB) begin
               phase_in = PH_STOPPED;
               emit     = 1'b1;
               q_data   = '{pixel_value: 8'd0, run_length: 8'd0, end_of_bitmap: 1'b1};
            end else if (req_enc_byte == ESC_DELTA) begin
               skip_in  = 2'd2;
               phase_in = PH_SKIP;
            end else begin
               lit_in   = req_enc_byte;
               pad_in   = req_enc_byte[0];
               phase_in = PH_LITERAL;
            end
         end
         PH_LITERAL: begin
            emit   = 1'b1;
            q_data = '{pixel_value: req_enc_byte, run_length: 8'd1, end_of_bitmap: 1'b0};
            lit_in = lit_dec;
            if (lit_dec == 8'd0) begin
               phase_in = pad_cur ? PH_PAD : PH_COUNT;
               pad_in   = 1'b0;
            end
         end
         PH_PAD: begin
            phase_in = PH_COUNT;
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 2'd0) begin
               phase_in = PH_COUNT;
            end
         end
         PH_STOPPED: begin
            phase_in = PH_STOPPED;
         end
         default: begin
            if (req_enc_byte != 8'd0) begin
               held_in  = req_enc_byte;
               phase_in = PH_VALUE;
            end else begin
               phase_in = PH_ESCAPE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         held_ff  <= 8'd0;
         lit_ff   <= 8'd0;
         pad_ff   <= 1'b0;
         skip_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         lit_ff   <= lit_in;
         pad_ff   <= pad_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

// File: src/brle_queue.sv
// short run descriptor queue between parser and output stage
// depends on brle_pkg

module brle_queue #(
   parameter int DEPTH = brle_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  brle_pkg::brle_run_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output brle_pkg::brle_run_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   brle_pkg::brle_run_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/brle_back.sv
// output stage: takes descriptors from the queue and presents them as result beats
// depends on brle_pkg

module brle_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  brle_pkg::brle_run_type q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_pixel_value,
   output logic [7:0]            rsp_run_length,
   output logic                  rsp_end_of_bitmap
);

   logic                   valid_ff, valid_in;
   brle_pkg::brle_run_type data_ff;

   assign q_pop    = q_not_empty && (!valid_ff || rsp_ready);
   assign valid_in = q_pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= q_data;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pixel_value   = data_ff.pixel_value;
   assign rsp_run_length    = data_ff.run_length;
   assign rsp_end_of_bitmap = data_ff.end_of_bitmap;

endmodule

// File: src/bmp_rle8_stream_decoder.sv
// top level of the bmp rle8 stream decoder: parser, queue and output stage
// depends on brle_pkg, brle_front, brle_queue, brle_back
//
//   channel   direction   ports                                        beat
//   req       in          req_enc_byte, req_frame_start                one encoded byte
//   rsp       out         rsp_pixel_value, rsp_run_length,             one run descriptor
//                         rsp_end_of_bitmap
//
// one byte accepted per cycle while the queue is not full; the parser state is registered
// a descriptor reaches rsp after its byte through the queue entry and then the output register
// req_ready drops only while the queue is full, which happens only after rsp stalls
// synchronous active-high reset clears parser phase, queue and output valid

module bmp_rle8_stream_decoder #(
   parameter int QUEUE_DEPTH = brle_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_enc_byte,
   input  logic       req_frame_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_pixel_value,
   output logic [7:0] rsp_run_length,
   output logic       rsp_end_of_bitmap
);

   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_not_empty;
   brle_pkg::brle_run_type push_data;
   brle_pkg::brle_run_type pop_data;

   brle_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_enc_byte    (req_enc_byte),
      .req_frame_start (req_frame_start),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (push_data)
   );

   brle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   brle_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_data            (pop_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_run_length    (rsp_run_length),
      .rsp_end_of_bitmap (rsp_end_of_bitmap)
   );

endmodule
